[design/sbeh_pkg.sv]
// Shared types and constants for the sensor bitmap event history block.
// No dependencies; imported by the controller, the datapath and the top level.
package sbeh_pkg;

  localparam int BANK_W   = 4;
  localparam int BITS_W   = 8;
  localparam int LETTER_W = 3;
  localparam int NUMBER_W = 5;
  localparam int EVENT_W  = LETTER_W + NUMBER_W;
  localparam int SCAN_W   = 3;

  localparam logic [LETTER_W-1:0] LETTER_MAX    = 3'd4;  // bank E
  localparam logic [NUMBER_W-1:0] NUM_EVEN_BASE = 5'd1;
  localparam logic [NUMBER_W-1:0] NUM_ODD_BASE  = 5'd9;
  localparam logic [SCAN_W-1:0]   SCAN_LAST     = 3'd7;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              take_item;  // latch the incoming byte
    logic              scan;       // examine one bit of the latched byte
    logic [SCAN_W-1:0] bit_idx;    // scan position, 0 is bit 7
    logic              load_out;   // move the read entry into the output register
  } sbeh_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic eop;         // latched end-of-poll flag
    logic hist_empty;  // no history entries
    logic snap_last;   // current snapshot index is the newest entry
    logic out_free;    // output register empty or being taken this cycle
  } sbeh_sts_t;

endpackage

[design/sbeh_ctrl.sv]
// Sequencer for the sensor bitmap event history: bit scan and snapshot readout.
// Depends on sbeh_pkg for the command and status structs.
module sbeh_ctrl
  import sbeh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output sbeh_cmd_t cmd,
  input  sbeh_sts_t sts
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RD, S_LD} state_t;

  state_t            state_r, state_nxt;
  logic [SCAN_W-1:0] bit_r, bit_nxt;
  logic              accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    bit_nxt       = bit_r;
    cmd.take_item = 1'b0;
    cmd.scan      = 1'b0;
    cmd.bit_idx   = bit_r;
    cmd.load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.take_item = 1'b1;
          bit_nxt       = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (bit_r == SCAN_LAST) begin
          state_nxt = sts.eop ? S_RD : S_IDLE;
        end else begin
          bit_nxt = bit_r + SCAN_W'(1);
        end
      end
      S_RD: begin
        // read address settles this cycle, data is registered for S_LD
        state_nxt = sts.hist_empty ? S_IDLE : S_LD;
      end
      S_LD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = sts.snap_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

`ifndef SYNTH
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN && bit_r == '0))
    else $error("accepted byte did not start a scan at bit 7");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output register loaded while occupied");

  a_scan_not_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && bit_r != SCAN_LAST) |=> (state_r == S_SCAN))
    else $error("scan ended before the last bit");
`endif

endmodule

[design/sbeh_dp.sv]
// Datapath for the sensor bitmap event history: item latch, event builder,
// history ring (memory, pointers, count) and output register. Uses sbeh_pkg.
module sbeh_dp
  import sbeh_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8,
  parameter int NUM_BANKS     = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [BANK_W-1:0]   in_bank_index,
  input  logic [BITS_W-1:0]   in_bank_bits,
  input  logic                in_end_of_poll,
  input  sbeh_cmd_t           cmd,
  output sbeh_sts_t           sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LETTER_W-1:0] out_bank_letter,
  output logic [NUMBER_W-1:0] out_sensor_number,
  output logic                out_entry_last
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = CW + 1;

  // Latched item
  logic [BANK_W-1:0] bank_r;
  logic [BITS_W-1:0] bits_r;
  logic              eop_r;

  // Ring state
  logic [EVENT_W-1:0] mem [HISTORY_DEPTH];
  logic [EVENT_W-1:0] rd_q;
  logic [EVENT_W-1:0] newest_r;
  logic [AW-1:0]      oldest_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      idx_r;

  // Output register
  logic                out_valid_r;
  logic [LETTER_W-1:0] out_letter_r;
  logic [NUMBER_W-1:0] out_number_r;
  logic                out_last_r;

  logic                bank_ok, hit, full, dup, rec;
  logic [LETTER_W-1:0] letter;
  logic [NUMBER_W-1:0] number;
  logic [EVENT_W-1:0]  ev;
  logic [SW-1:0]       wsum, rsum;
  logic [AW-1:0]       wr_slot, rd_slot;

  assign bank_ok = (bank_r < BANK_W'(NUM_BANKS));
  assign hit     = bank_ok && bits_r[SCAN_LAST - cmd.bit_idx];
  assign letter  = (bank_r[BANK_W-1:1] > LETTER_MAX) ? LETTER_MAX : bank_r[BANK_W-1:1];
  assign number  = bank_r[0] ? (NUM_ODD_BASE + NUMBER_W'(cmd.bit_idx))
                             : (NUM_EVEN_BASE + NUMBER_W'(cmd.bit_idx));
  assign ev      = {letter, number};

  assign full = (count_r == CW'(HISTORY_DEPTH));
  assign dup  = (count_r != '0) && (newest_r == ev);
  assign rec  = cmd.scan && hit && !dup;

  // Ring slot = (oldest + offset) mod depth; the sum stays below twice the depth
  always_comb begin
    wsum = SW'(oldest_r) + SW'(count_r);
    if (wsum >= SW'(HISTORY_DEPTH)) begin
      wsum = wsum - SW'(HISTORY_DEPTH);
    end
    rsum = SW'(oldest_r) + SW'(idx_r);
    if (rsum >= SW'(HISTORY_DEPTH)) begin
      rsum = rsum - SW'(HISTORY_DEPTH);
    end
    // when full, the new entry overwrites the oldest slot
    wr_slot = full ? oldest_r : wsum[AW-1:0];
    rd_slot = rsum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rec) begin
      mem[wr_slot] <= ev;
    end
    rd_q <= mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      bank_r <= in_bank_index;
      bits_r <= in_bank_bits;
    end
    if (rec) begin
      newest_r <= ev;
    end
    if (cmd.load_out) begin
      out_letter_r <= rd_q[EVENT_W-1 -: LETTER_W];
      out_number_r <= rd_q[NUMBER_W-1:0];
      out_last_r   <= sts.snap_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eop_r       <= 1'b0;
      oldest_r    <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take_item) begin
        eop_r <= in_end_of_poll;
        idx_r <= '0;
      end else if (cmd.load_out) begin
        idx_r <= idx_r + CW'(1);
      end
      if (rec) begin
        if (full) begin
          oldest_r <= (oldest_r == AW'(HISTORY_DEPTH - 1)) ? '0 : oldest_r + AW'(1);
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.eop        = eop_r;
  assign sts.hist_empty = (count_r == '0);
  assign sts.snap_last  = ((SW'(idx_r) + SW'(1)) == SW'(count_r));
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_bank_letter   = out_letter_r;
  assign out_sensor_number = out_number_r;
  assign out_entry_last    = out_last_r;

`ifndef SYNTH
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HISTORY_DEPTH))
    else $error("history count beyond ring depth");

  a_count_never_drops: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r >= $past(count_r)))
    else $error("history count decreased outside reset");

  a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !rec)
    else $error("ring written during snapshot readout");
`endif

endmodule

[design/sensor_bitmap_event_history.sv]
// Top level of the sensor bitmap event history block.
// Instantiates sbeh_ctrl and sbeh_dp; types and constants from sbeh_pkg.
//
// Usage:
//   Input channel (in_*): one polled half-bank byte per transfer, with its bank
//   index and an end-of-poll flag. Set bits are scanned from bit 7 down; each
//   becomes an event (letter = bank/2 capped at E, number = position + 1 or
//   + 9 for odd banks) that is appended to an eight-entry history ring unless
//   it repeats the newest entry. A full ring drops its oldest entry first.
//   Output channel (out_*): on end of poll the whole history is sent oldest to
//   newest, one entry per transfer, out_entry_last high on the newest one.
//   Timing: a byte is scanned one bit per cycle, and in_stall stays high for
//   the whole scan and any readout (the scan counter sets the rate). With end
//   of poll, readout goes through S_RD and S_LD for each entry (S_RD alone on
//   an empty history) through the single ring read port.
//   An empty history gives no results. The next byte is taken while the last
//   entry still sits in the output register.
//   Receiver stall: readout holds with the entry in the output register until
//   out_stall falls; no entry is lost or repeated.
//   Reset (rst_n low, synchronous): empties the history, clears pointers and
//   drops any pending output. Ring contents need no clearing.
module sensor_bitmap_event_history
  import sbeh_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8,
  parameter int NUM_BANKS     = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BANK_W-1:0]   in_bank_index,
  input  logic [BITS_W-1:0]   in_bank_bits,
  input  logic                in_end_of_poll,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LETTER_W-1:0] out_bank_letter,
  output logic [NUMBER_W-1:0] out_sensor_number,
  output logic                out_entry_last
);

  // Command and status between sequencer and datapath
  sbeh_cmd_t cmd;
  sbeh_sts_t sts;

  // Sequencer: accept, bit scan, snapshot readout
  sbeh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: event builder, history ring and output register
  sbeh_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .NUM_BANKS     (NUM_BANKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_bank_index     (in_bank_index),
    .in_bank_bits      (in_bank_bits),
    .in_end_of_poll    (in_end_of_poll),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bank_letter   (out_bank_letter),
    .out_sensor_number (out_sensor_number),
    .out_entry_last    (out_entry_last)
  );

endmodule
